// ----- rtl/state_vector_measure_collapse_defines.svh -----
// Assertion macros shared by the state vector measurement RTL.
// Depends on nothing; the asserting modules provide clk and arst_n.
`ifndef STATE_VECTOR_MEASURE_COLLAPSE_DEFINES_SVH
`define STATE_VECTOR_MEASURE_COLLAPSE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SVMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SVMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVMC_ASSERT(lbl, prop, msg)
`define SVMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/svmc_pkg.sv -----
// Shared constants and types for the state vector measurement block.
// Depends on nothing.
package svmc_pkg;

	localparam int QUBITS_DEF = 10;
	localparam int AMP_W = 16;
	localparam int PROB_W = 17;
	localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;
	localparam int MAG_W = 32;
	localparam int DVD_W = 61;
	localparam int SQ_W = 62;
	localparam int DIV_STEPS = 61;
	localparam int SQRT_STEPS = 31;
	localparam int STEP_W = 6;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_MEASURE = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	typedef struct packed {
		logic start;
		logic signed [AMP_W-1:0] part;
	} scl_req_t;

	typedef struct packed {
		logic done;
		logic signed [AMP_W-1:0] result;
	} scl_rsp_t;

endpackage

// ----- rtl/svmc_scale.sv -----
// Rescales one amplitude part by the reciprocal square root of the norm.
// Uses svmc_pkg and the assertion macros of the defines header.
`include "state_vector_measure_collapse_defines.svh"
module svmc_scale #(
	parameter int NORM_W = svmc_pkg::MAG_W + svmc_pkg::QUBITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svmc_pkg::scl_req_t    req,
	input  logic [NORM_W-1:0]     norm,
	output svmc_pkg::scl_rsp_t    rsp
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SQRT, S_FIN} st_t;

	st_t st_q;
	logic neg_q;
	logic [svmc_pkg::AMP_W:0] mag_q;
	logic [svmc_pkg::DVD_W-1:0] dvd_q;
	logic [NORM_W-1:0] rem_q;
	logic [svmc_pkg::SQ_W-1:0] rad_q, res_q, bit_q;
	logic [svmc_pkg::STEP_W-1:0] cnt_q;
	svmc_pkg::scl_rsp_t rsp_q;

	logic signed [svmc_pkg::AMP_W:0] part_ext;
	logic [svmc_pkg::AMP_W:0] part_mag;
	logic [2*svmc_pkg::AMP_W+1:0] sq;
	logic [NORM_W:0] trial;
	logic qbit;
	logic [svmc_pkg::SQ_W-1:0] tsum;
	logic [svmc_pkg::AMP_W-1:0] sat;

	always_comb begin
		part_ext = {req.part[svmc_pkg::AMP_W-1], req.part};
		part_mag = part_ext[svmc_pkg::AMP_W] ? $unsigned(-part_ext) : $unsigned(part_ext);
		sq = mag_q * mag_q;
		trial = {rem_q, dvd_q[svmc_pkg::DVD_W-1]};
		qbit = (trial >= {1'b0, norm});
		tsum = res_q + bit_q;
		if (neg_q) begin
			sat = (res_q > svmc_pkg::SQ_W'(32768)) ? 16'h8000 : 16'(-res_q);
		end else begin
			sat = (res_q > svmc_pkg::SQ_W'(32767)) ? 16'h7FFF : res_q[svmc_pkg::AMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rsp_q <= '0;
			cnt_q <= '0;
		end else begin
			rsp_q.done <= (st_q == S_FIN);
			unique case (st_q)
				S_IDLE: begin
					if (req.start) begin
						neg_q <= req.part[svmc_pkg::AMP_W-1];
						mag_q <= part_mag;
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					dvd_q <= {sq[30:0], 30'd0};
					rem_q <= '0;
					cnt_q <= svmc_pkg::STEP_W'(svmc_pkg::DIV_STEPS - 1);
					st_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= qbit ? NORM_W'(trial - {1'b0, norm}) : trial[NORM_W-1:0];
					dvd_q <= {dvd_q[svmc_pkg::DVD_W-2:0], qbit};
					if (cnt_q == '0) begin
						rad_q <= {1'b0, dvd_q[svmc_pkg::DVD_W-2:0], qbit};
						res_q <= '0;
						bit_q <= svmc_pkg::SQ_W'(1) << 60;
						cnt_q <= svmc_pkg::STEP_W'(svmc_pkg::SQRT_STEPS - 1);
						st_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQRT: begin
					if (rad_q >= tsum) begin
						rad_q <= rad_q - tsum;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == '0) begin
						st_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					rsp_q.result <= sat;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;

	`SVMC_ASSERT_ALWAYS(a_start_when_idle, req.start |-> st_q == S_IDLE, "scale start while busy")
	`SVMC_ASSERT(a_done_after_fin, rsp_q.done |-> $past(st_q == S_FIN), "done without final step")
	`SVMC_ASSERT(a_div_to_sqrt, (st_q == S_DIV && cnt_q == '0) |=> st_q == S_SQRT, "divide overrun")

endmodule

// ----- rtl/state_vector_measure_collapse.sv -----
// Top level: amplitude memory, measurement sequencer and output register.
// Uses svmc_pkg, svmc_scale and the assertion macros of the defines header.
//
//   channel | signals                                   | direction
//   in      | in_valid in_ready func index amp_re ...   | into the block
//   out     | out_valid out_ready outcome probability...| out of the block
//
// A write is stored as it is accepted; a read fetches the word, then waits on the output.
// A measure makes a probability pass over every entry (read, square, accumulate),
// then a collapse pass that zeroes entries of the other outcome and rescales both
// parts of each survivor in the shared bit-serial divider and square root unit.
// Reset clears only control state; the memory holds nothing until written.
// in_ready is low while an item is in work; a held result does not block writes.
`include "state_vector_measure_collapse_defines.svh"
module state_vector_measure_collapse #(
	parameter int QUBITS = svmc_pkg::QUBITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [9:0]         index,
	input  logic signed [15:0] amp_re,
	input  logic signed [15:0] amp_im,
	input  logic [3:0]         qubit,
	input  logic [15:0]        random,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               outcome,
	output logic [16:0]        probability,
	output logic signed [15:0] read_re,
	output logic signed [15:0] read_im
);

	localparam int AW = QUBITS;
	localparam int DEPTH = 1 << AW;
	localparam int SUM_W = svmc_pkg::MAG_W + AW;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SUM_RD, S_SUM_MAG, S_SUM_ACC, S_DECIDE,
		S_COL_RD, S_COL_DAT, S_COL_RE, S_COL_IM, S_DONE
	} state_t;

	state_t state_q;
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;
	logic [AW-1:0] cnt_q;
	logic [3:0] qubit_q;
	logic [15:0] random_q;
	logic [svmc_pkg::MAG_W-1:0] mag_q;
	logic [SUM_W-1:0] total_q, sum1_q, norm_q;
	logic outc_q;
	logic [svmc_pkg::PROB_W-1:0] prob_q;
	logic signed [15:0] re_q, im_q;
	logic out_valid_q, outcome_q;
	logic [16:0] probability_q;
	logic signed [15:0] read_re_q, read_im_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata;
	logic [AW-1:0] cnt_shift;
	logic selb, match, out_free, out_load, in_acc;
	logic signed [31:0] pre, pim;
	logic [svmc_pkg::MAG_W-1:0] mag_c;
	logic [SUM_W-1:0] p_raw;
	logic [svmc_pkg::PROB_W-1:0] p16;
	logic outc_c;
	svmc_pkg::scl_req_t req;
	svmc_pkg::scl_rsp_t rsp;

	always_comb begin
		in_acc = in_valid && (state_q == S_IDLE);
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == S_READ || state_q == S_DONE) && out_free;
		cnt_shift = cnt_q >> qubit_q;
		selb = (32'(qubit_q) < QUBITS) ? cnt_shift[0] : 1'b0;
		match = (selb == outc_q);
		pre = $signed(rdata_q[31:16]) * $signed(rdata_q[31:16]);
		pim = $signed(rdata_q[15:0]) * $signed(rdata_q[15:0]);
		mag_c = $unsigned(pre) + $unsigned(pim);
		p_raw = sum1_q >> 14;
		p16 = (p_raw > SUM_W'(svmc_pkg::PROB_ONE)) ? svmc_pkg::PROB_ONE
			: p_raw[svmc_pkg::PROB_W-1:0];
		outc_c = ({1'b0, random_q} < p16);
		mem_raddr = (state_q == S_IDLE) ? AW'(index) : cnt_q;
		mem_we = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		if (in_acc && func == svmc_pkg::FUNC_WRITE) begin
			mem_we = 1'b1;
			mem_waddr = AW'(index);
			mem_wdata = {amp_re, amp_im};
		end else if (state_q == S_COL_DAT && !match) begin
			mem_we = 1'b1;
		end else if (state_q == S_COL_IM && rsp.done) begin
			mem_we = 1'b1;
			mem_wdata = {re_q, rsp.result};
		end
		req.start = (state_q == S_COL_DAT && match && norm_q != '0)
			|| (state_q == S_COL_RE && rsp.done);
		req.part = (state_q == S_COL_DAT) ? $signed(rdata_q[31:16]) : im_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q != S_READ) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	svmc_scale #(.NORM_W(SUM_W)) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.norm(norm_q),
		.rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (func)
							svmc_pkg::FUNC_READ: state_q <= S_READ;
							svmc_pkg::FUNC_MEASURE: begin
								qubit_q <= qubit;
								random_q <= random;
								total_q <= '0;
								sum1_q <= '0;
								cnt_q <= '0;
								state_q <= S_SUM_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					if (out_free) begin
						outcome_q <= 1'b0;
						probability_q <= '0;
						read_re_q <= rdata_q[31:16];
						read_im_q <= rdata_q[15:0];
						state_q <= S_IDLE;
					end
				end
				S_SUM_RD: state_q <= S_SUM_MAG;
				S_SUM_MAG: begin
					mag_q <= mag_c;
					state_q <= S_SUM_ACC;
				end
				S_SUM_ACC: begin
					total_q <= total_q + SUM_W'(mag_q);
					if (selb) begin
						sum1_q <= sum1_q + SUM_W'(mag_q);
					end
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == AW'(DEPTH - 1)) ? S_DECIDE : S_SUM_RD;
				end
				S_DECIDE: begin
					outc_q <= outc_c;
					prob_q <= outc_c ? p16 : svmc_pkg::PROB_ONE - p16;
					norm_q <= outc_c ? sum1_q : total_q - sum1_q;
					cnt_q <= '0;
					state_q <= S_COL_RD;
				end
				S_COL_RD: state_q <= S_COL_DAT;
				S_COL_DAT: begin
					im_q <= rdata_q[15:0];
					if (req.start) begin
						state_q <= S_COL_RE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= (cnt_q == AW'(DEPTH - 1)) ? S_DONE : S_COL_RD;
					end
				end
				S_COL_RE: begin
					if (rsp.done) begin
						re_q <= rsp.result;
						state_q <= S_COL_IM;
					end
				end
				S_COL_IM: begin
					if (rsp.done) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= (cnt_q == AW'(DEPTH - 1)) ? S_DONE : S_COL_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						outcome_q <= outc_q;
						probability_q <= prob_q;
						read_re_q <= '0;
						read_im_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign probability = probability_q;
	assign read_re = read_re_q;
	assign read_im = read_im_q;

	`SVMC_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(state_q == S_READ || state_q == S_DONE), "result from wrong state")
	`SVMC_ASSERT(a_done_in_col, rsp.done |-> (state_q == S_COL_RE || state_q == S_COL_IM), "stray scale result")
	`SVMC_ASSERT(a_we_in_measure, (mem_we && state_q != S_IDLE) |-> (state_q == S_COL_DAT || state_q == S_COL_IM), "stray memory write")

endmodule
